### design/btm_pkg.sv
// ----------------------------------------------------------------------------
// btm_pkg: shared definitions for the bracket tape machine
// Sizes, status codes, command codes, program characters and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package btm_pkg;

  localparam int TAPE_CELLS = 1024;
  localparam int PROG_DEPTH = 4096;
  localparam int CELL_WIDTH = 16;

  localparam int IP_W = $clog2(PROG_DEPTH + 1);
  localparam int PA_W = $clog2(PROG_DEPTH);
  localparam int DP_W = $clog2(TAPE_CELLS);

  typedef logic [2:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_HALT      = 3'd1;
  localparam status_t ST_MISMATCH  = 3'd2;
  localparam status_t ST_UNDERFLOW = 3'd3;
  localparam status_t ST_TAPE_FULL = 3'd4;
  localparam status_t ST_PROG_FULL = 3'd5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'd91;
  localparam logic [7:0] CH_CLOSE = 8'd93;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic fetch;
    logic exec;
    logic peek1;
    logic peek2;
    logic scan_addr;
    logic scan_data;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic step_go;
    logic ex_peek;
    logic ex_scan;
    logic pk_scan;
    logic scan_oob;
    logic scan_found;
    logic out_busy;
  } dp_stat_t;

endpackage

### design/btm_in_if.sv
// ----------------------------------------------------------------------------
// btm_in_if: request channel into the tape machine
// Valid/ready handshake with load and step request fields.
// ----------------------------------------------------------------------------
interface btm_in_if;
  import btm_pkg::*;

  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] code_byte;
  logic [7:0] input_byte;
  logic       input_eof;

  modport source (output valid, command, code_byte, input_byte, input_eof, input ready);
  modport sink   (input valid, command, code_byte, input_byte, input_eof, output ready);
endinterface

### design/btm_out_if.sv
// ----------------------------------------------------------------------------
// btm_out_if: result channel out of the tape machine
// Valid/ready handshake with one result per request.
// ----------------------------------------------------------------------------
interface btm_out_if;
  import btm_pkg::*;

  logic       valid;
  logic       ready;
  status_t    status;
  logic       output_valid;
  logic [7:0] output_byte;
  logic       input_taken;

  modport source (output valid, status, output_valid, output_byte, input_taken, input ready);
  modport sink   (input valid, status, output_valid, output_byte, input_taken, output ready);
endinterface

### design/bracket_tape_machine_core_top.sv
// ----------------------------------------------------------------------------
// bracket_tape_machine_core_top: eight-command tape machine
// Load requests append code bytes; step requests run one instruction on a
// tape of 16-bit wrapping cells and return one result each.
// ----------------------------------------------------------------------------
// After reset the tape is swept to zero, one cell a cycle, so no request is
// taken until the sweep is done. Requests are handled one at a time and
// each gives exactly one result, held in an output register so the next
// request can be taken while it waits. A load, and a step while stopped or at
// end of program, go straight to the result; a plain step reads program and
// tape, one registered read each, then executes with the tape write-back; a
// "[-]" clear first reads the two following code bytes through the single
// program read port. A bracket jump walks the program one byte at a time,
// an address step and a data step per byte, after a "[" has first read its
// two following code bytes where there are two, and ends in a mismatch when
// the walk runs off the program. Errors and end of program stick until reset.
// ----------------------------------------------------------------------------
module bracket_tape_machine_core_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  btm_in_if.sink   in_i,
  btm_out_if.source out_o
);
  import btm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  btm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  btm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .command_i      (in_i.command),
    .code_byte_i    (in_i.code_byte),
    .input_byte_i   (in_i.input_byte),
    .input_eof_i    (in_i.input_eof),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .status_o       (out_o.status),
    .output_valid_o (out_o.output_valid),
    .output_byte_o  (out_o.output_byte),
    .input_taken_o  (out_o.input_taken)
  );

endmodule

### design/btm_ram.sv
// ----------------------------------------------------------------------------
// btm_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/btm_ctrl.sv
// ----------------------------------------------------------------------------
// btm_ctrl: sequencer of the tape machine
// Runs the tape clearing pass, then walks each runnable step through fetch,
// execute, bracket peek and scan steps, and hands every result out.
// ----------------------------------------------------------------------------
module btm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  btm_pkg::dp_stat_t    stat_i,
  output btm_pkg::ctrl_cmd_t   cmd_o
);
  import btm_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_FETCH  = 9'b000000100,
    S_EXEC   = 9'b000001000,
    S_PEEK1  = 9'b000010000,
    S_PEEK2  = 9'b000100000,
    S_SCAN_A = 9'b001000000,
    S_SCAN_D = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.step_go ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.ex_peek) begin
          state_d = S_PEEK1;
        end else if (stat_i.ex_scan) begin
          state_d = S_SCAN_A;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PEEK1: begin
        cmd_o.peek1 = 1'b1;
        state_d = S_PEEK2;
      end
      S_PEEK2: begin
        cmd_o.peek2 = 1'b1;
        state_d = stat_i.pk_scan ? S_SCAN_A : S_DONE;
      end
      S_SCAN_A: begin
        cmd_o.scan_addr = 1'b1;
        state_d = stat_i.scan_oob ? S_DONE : S_SCAN_D;
      end
      S_SCAN_D: begin
        cmd_o.scan_data = 1'b1;
        state_d = stat_i.scan_found ? S_DONE : S_SCAN_A;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/btm_datapath.sv
// ----------------------------------------------------------------------------
// btm_datapath: storage and arithmetic of the tape machine
// Program and tape memories, pointers, stop code, bracket scan
// registers and the output register.
// ----------------------------------------------------------------------------
module btm_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  btm_pkg::ctrl_cmd_t   cmd_i,
  output btm_pkg::dp_stat_t    stat_o,
  input  logic                 command_i,
  input  logic [7:0]           code_byte_i,
  input  logic [7:0]           input_byte_i,
  input  logic                 input_eof_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output btm_pkg::status_t     status_o,
  output logic                 output_valid_o,
  output logic [7:0]           output_byte_o,
  output logic                 input_taken_o
);
  import btm_pkg::*;

  logic [IP_W-1:0]       len_q, len_d, ip_q, ip_d;
  logic [DP_W-1:0]       dp_q, dp_d, clr_cnt_q, clr_cnt_d;
  status_t               stop_q, stop_d;
  logic                  out_valid_q, out_valid_d;

  logic [7:0]            op_q, op_d;
  logic [CELL_WIDTH-1:0] cell_q, cell_d;
  logic [7:0]            ibyte_q, ibyte_d;
  logic                  ieof_q, ieof_d;
  logic                  b1_q, b1_d;
  logic [IP_W-1:0]       pos_q, pos_d, depth_q, depth_d;
  logic                  back_q, back_d;
  status_t               res_status_q, res_status_d;
  logic                  res_ovalid_q, res_ovalid_d;
  logic [7:0]            res_obyte_q, res_obyte_d;
  logic                  res_itaken_q, res_itaken_d;
  status_t               out_status_q, out_status_d;
  logic                  out_ovalid_q, out_ovalid_d;
  logic [7:0]            out_obyte_q, out_obyte_d;
  logic                  out_itaken_q, out_itaken_d;

  logic                  prog_we;
  logic [PA_W-1:0]       prog_waddr, prog_raddr;
  logic [7:0]            prog_wdata, prog_rdata;
  logic                  tape_we;
  logic [DP_W-1:0]       tape_waddr, tape_raddr;
  logic [CELL_WIDTH-1:0] tape_wdata, tape_rdata;

  logic                  peek_ok, cell_zero, clr_pat;
  logic                  rd_open, rd_close, d_inc, d_dec;

  btm_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (prog_wdata),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rdata)
  );

  btm_ram #(.WIDTH(CELL_WIDTH), .DEPTH(TAPE_CELLS)) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (tape_raddr),
    .rdata_o (tape_rdata)
  );

  assign peek_ok   = ({1'b0, ip_q} + (IP_W+1)'(2)) < {1'b0, len_q};
  assign cell_zero = (cell_q == '0);
  assign clr_pat   = b1_q && (prog_rdata == CH_CLOSE);
  assign rd_open   = (prog_rdata == CH_OPEN);
  assign rd_close  = (prog_rdata == CH_CLOSE);
  assign d_inc     = back_q ? rd_close : rd_open;
  assign d_dec     = back_q ? rd_open : rd_close;

  always_comb begin
    stat_o.clr_last   = (clr_cnt_q == DP_W'(TAPE_CELLS - 1));
    stat_o.step_go    = (command_i == CMD_STEP) && (stop_q == ST_OK) && (ip_q < len_q);
    stat_o.ex_peek    = (op_q == CH_OPEN) && peek_ok;
    stat_o.ex_scan    = ((op_q == CH_OPEN) && !peek_ok && cell_zero) || (op_q == CH_CLOSE);
    stat_o.pk_scan    = !clr_pat && cell_zero;
    stat_o.scan_oob   = back_q ? (pos_q == '0)
                               : (({1'b0, pos_q} + (IP_W+1)'(1)) >= {1'b0, len_q});
    stat_o.scan_found = d_dec && (depth_q == IP_W'(1));
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_comb begin
    len_d        = len_q;
    ip_d         = ip_q;
    dp_d         = dp_q;
    clr_cnt_d    = clr_cnt_q;
    stop_d       = stop_q;
    op_d         = op_q;
    cell_d       = cell_q;
    ibyte_d      = ibyte_q;
    ieof_d       = ieof_q;
    b1_d         = b1_q;
    pos_d        = pos_q;
    depth_d      = depth_q;
    back_d       = back_q;
    res_status_d = res_status_q;
    res_ovalid_d = res_ovalid_q;
    res_obyte_d  = res_obyte_q;
    res_itaken_d = res_itaken_q;
    out_status_d = out_status_q;
    out_ovalid_d = out_ovalid_q;
    out_obyte_d  = out_obyte_q;
    out_itaken_d = out_itaken_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    prog_we    = 1'b0;
    prog_waddr = len_q[PA_W-1:0];
    prog_wdata = code_byte_i;
    prog_raddr = ip_q[PA_W-1:0];
    tape_we    = 1'b0;
    tape_waddr = dp_q;
    tape_wdata = '0;
    tape_raddr = dp_q;

    if (cmd_i.clr_step) begin
      tape_we    = 1'b1;
      tape_waddr = clr_cnt_q;
      clr_cnt_d  = clr_cnt_q + DP_W'(1);
    end

    if (cmd_i.accept) begin
      ibyte_d      = input_byte_i;
      ieof_d       = input_eof_i;
      res_status_d = stop_q;
      res_ovalid_d = 1'b0;
      res_obyte_d  = '0;
      res_itaken_d = 1'b0;
      if (command_i == CMD_LOAD) begin
        if (len_q < IP_W'(PROG_DEPTH)) begin
          prog_we = 1'b1;
          len_d   = len_q + IP_W'(1);
        end else begin
          res_status_d = ST_PROG_FULL;
        end
      end else if (stop_q == ST_OK && ip_q >= len_q) begin
        stop_d       = ST_HALT;
        res_status_d = ST_HALT;
      end
    end

    if (cmd_i.fetch) begin
      op_d   = prog_rdata;
      cell_d = tape_rdata;
    end

    if (cmd_i.exec) begin
      case (op_q)
        CH_RIGHT: begin
          if (dp_q == DP_W'(TAPE_CELLS - 1)) begin
            stop_d       = ST_TAPE_FULL;
            res_status_d = ST_TAPE_FULL;
          end else begin
            dp_d = dp_q + DP_W'(1);
            ip_d = ip_q + IP_W'(1);
          end
        end
        CH_LEFT: begin
          if (dp_q == '0) begin
            stop_d       = ST_UNDERFLOW;
            res_status_d = ST_UNDERFLOW;
          end else begin
            dp_d = dp_q - DP_W'(1);
            ip_d = ip_q + IP_W'(1);
          end
        end
        CH_INC: begin
          tape_we    = 1'b1;
          tape_wdata = cell_q + CELL_WIDTH'(1);
          ip_d       = ip_q + IP_W'(1);
        end
        CH_DEC: begin
          tape_we    = 1'b1;
          tape_wdata = cell_q - CELL_WIDTH'(1);
          ip_d       = ip_q + IP_W'(1);
        end
        CH_OUT: begin
          res_ovalid_d = 1'b1;
          res_obyte_d  = cell_q[7:0];
          ip_d         = ip_q + IP_W'(1);
        end
        CH_IN: begin
          tape_we      = 1'b1;
          tape_wdata   = ieof_q ? '0 : CELL_WIDTH'(ibyte_q);
          res_itaken_d = !ieof_q;
          ip_d         = ip_q + IP_W'(1);
        end
        CH_OPEN: begin
          if (peek_ok) begin
            prog_raddr = ip_q[PA_W-1:0] + PA_W'(1);
          end else if (cell_zero) begin
            pos_d   = ip_q;
            depth_d = IP_W'(1);
            back_d  = 1'b0;
          end else begin
            ip_d = ip_q + IP_W'(1);
          end
        end
        CH_CLOSE: begin
          pos_d   = ip_q;
          depth_d = IP_W'(1);
          back_d  = 1'b1;
        end
        default: begin
          ip_d = ip_q + IP_W'(1);
        end
      endcase
    end

    if (cmd_i.peek1) begin
      b1_d       = (prog_rdata == CH_DEC);
      prog_raddr = ip_q[PA_W-1:0] + PA_W'(2);
    end

    if (cmd_i.peek2) begin
      if (clr_pat) begin
        tape_we    = 1'b1;
        tape_wdata = '0;
        ip_d       = ip_q + IP_W'(3);
      end else if (cell_zero) begin
        pos_d   = ip_q;
        depth_d = IP_W'(1);
        back_d  = 1'b0;
      end else begin
        ip_d = ip_q + IP_W'(1);
      end
    end

    if (cmd_i.scan_addr) begin
      if (stat_o.scan_oob) begin
        stop_d       = ST_MISMATCH;
        res_status_d = ST_MISMATCH;
      end else begin
        pos_d      = back_q ? (pos_q - IP_W'(1)) : (pos_q + IP_W'(1));
        prog_raddr = pos_d[PA_W-1:0];
      end
    end

    if (cmd_i.scan_data) begin
      if (d_inc) begin
        depth_d = depth_q + IP_W'(1);
      end else if (d_dec) begin
        depth_d = depth_q - IP_W'(1);
      end
      if (stat_o.scan_found) begin
        ip_d = back_q ? pos_q : (pos_q + IP_W'(1));
      end
    end

    if (cmd_i.out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_ovalid_d = res_ovalid_q;
      out_obyte_d  = res_obyte_q;
      out_itaken_d = res_itaken_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ip_q        <= '0;
      dp_q        <= '0;
      clr_cnt_q   <= '0;
      stop_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ip_q        <= ip_d;
      dp_q        <= dp_d;
      clr_cnt_q   <= clr_cnt_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    cell_q       <= cell_d;
    ibyte_q      <= ibyte_d;
    ieof_q       <= ieof_d;
    b1_q         <= b1_d;
    pos_q        <= pos_d;
    depth_q      <= depth_d;
    back_q       <= back_d;
    res_status_q <= res_status_d;
    res_ovalid_q <= res_ovalid_d;
    res_obyte_q  <= res_obyte_d;
    res_itaken_q <= res_itaken_d;
    out_status_q <= out_status_d;
    out_ovalid_q <= out_ovalid_d;
    out_obyte_q  <= out_obyte_d;
    out_itaken_q <= out_itaken_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign output_valid_o = out_ovalid_q;
  assign output_byte_o  = out_obyte_q;
  assign input_taken_o  = out_itaken_q;

endmodule

### design/btm_checker.sv
// ----------------------------------------------------------------------------
// btm_checker: port level checks of the tape machine
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module btm_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input btm_pkg::status_t status_i,
  input logic             output_valid_i,
  input logic [7:0]       output_byte_i,
  input logic             input_taken_i
);
  import btm_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(output_valid_i)
      && $stable(output_byte_i) && $stable(input_taken_i))
    else $error("stalled result changed");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken back to back");

  a_output_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && output_valid_i |-> status_i == ST_OK && !input_taken_i)
    else $error("output flag with error status or input flag");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_PROG_FULL)
    else $error("status code out of range");

endmodule

bind bracket_tape_machine_core_top btm_checker u_btm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .output_valid_i (out_o.output_valid),
  .output_byte_i  (out_o.output_byte),
  .input_taken_i  (out_o.input_taken)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bracket tape machine
// Loads programs byte by byte and single-steps them, predicting every result
// from an internal copy of program store, tape and pointers. Directed cases
// cover each instruction, wrap-round and a late "[-]" clear; random programs
// are built from balanced segments (counted and nested loops, skipped blocks,
// straight-line code with stray bytes). The run ends on one randomly chosen
// stop condition, then loads a few more bytes while stopped.
// ----------------------------------------------------------------------------
module tb_top;
  import btm_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_LIMIT  = 40000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    status_t    status;
    logic       output_valid;
    logic [7:0] output_byte;
    logic       input_taken;
  } machine_result_t;

  typedef enum int {
    SEG_STRAIGHT, SEG_CLEAR, SEG_COUNTED, SEG_NESTED, SEG_SKIPPED, SEG_SHIFT
  } segment_kind_e;

  typedef enum int {
    END_HALT, END_UNDERFLOW, END_OPEN_UNMATCHED, END_CLOSE_UNMATCHED
  } ending_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  btm_in_if  req_if ();
  btm_out_if rsp_if ();

  bracket_tape_machine_core_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // machine state as the block should hold it
  logic [7:0]            prog_mem [PROG_DEPTH];
  logic [CELL_WIDTH-1:0] tape_mem [TAPE_CELLS];
  int unsigned           code_len;
  int unsigned           instr_ptr;
  int unsigned           data_ptr;
  status_t               halt_code;

  machine_result_t outcome_q[$];
  logic [7:0]      code_backlog[$];
  int unsigned     runnable_len;
  int unsigned     plan_dp;
  bit              steady;
  int              fail_count;
  int              result_count;
  int              quiet_cycles;

  function automatic bit find_partner(input bit forward, output int unsigned at);
    int pos;
    int depth;
    pos   = int'(instr_ptr);
    depth = 1;
    at    = instr_ptr;
    while (depth > 0) begin
      pos = forward ? pos + 1 : pos - 1;
      if (pos < 0 || pos >= int'(code_len)) return 1'b0;
      if (prog_mem[pos] == CH_OPEN) depth += forward ? 1 : -1;
      else if (prog_mem[pos] == CH_CLOSE) depth -= forward ? 1 : -1;
    end
    at = pos;
    return 1'b1;
  endfunction

  function automatic machine_result_t run_machine_item(input logic cmd, input logic [7:0] code,
                                                       input logic [7:0] ib, input logic eof);
    machine_result_t r;
    int unsigned     next_ip;
    int unsigned     hit;
    logic [7:0]      op;
    r = '0;
    if (cmd == CMD_LOAD) begin
      if (code_len < PROG_DEPTH) begin
        prog_mem[code_len] = code;
        code_len++;
        r.status = halt_code;
      end else begin
        r.status = ST_PROG_FULL;
      end
    end else if (halt_code != ST_OK) begin
      r.status = halt_code;
    end else if (instr_ptr >= code_len) begin
      halt_code = ST_HALT;
      r.status  = ST_HALT;
    end else begin
      op      = prog_mem[instr_ptr];
      next_ip = instr_ptr + 1;
      case (op)
        CH_RIGHT: begin
          if (data_ptr >= TAPE_CELLS - 1) halt_code = ST_TAPE_FULL;
          else data_ptr++;
        end
        CH_LEFT: begin
          if (data_ptr == 0) halt_code = ST_UNDERFLOW;
          else data_ptr--;
        end
        CH_INC: tape_mem[data_ptr] = tape_mem[data_ptr] + 1'b1;
        CH_DEC: tape_mem[data_ptr] = tape_mem[data_ptr] - 1'b1;
        CH_OUT: begin
          r.output_valid = 1'b1;
          r.output_byte  = tape_mem[data_ptr][7:0];
        end
        CH_IN: begin
          if (eof) begin
            tape_mem[data_ptr] = '0;
          end else begin
            tape_mem[data_ptr] = CELL_WIDTH'(ib);
            r.input_taken      = 1'b1;
          end
        end
        CH_OPEN: begin
          if (instr_ptr + 2 < code_len && prog_mem[instr_ptr + 1] == CH_DEC &&
              prog_mem[instr_ptr + 2] == CH_CLOSE) begin
            tape_mem[data_ptr] = '0;
            next_ip = instr_ptr + 3;
          end else if (tape_mem[data_ptr] == '0) begin
            if (find_partner(1'b1, hit)) next_ip = hit + 1;
            else halt_code = ST_MISMATCH;
          end
        end
        CH_CLOSE: begin
          if (find_partner(1'b0, hit)) next_ip = hit;
          else halt_code = ST_MISMATCH;
        end
        default: ;
      endcase
      if (halt_code != ST_OK) begin
        r        = '0;
        r.status = halt_code;
      end else begin
        instr_ptr = next_ip;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    bit         again;
    again = 1'b1;
    while (again) begin
      b = 8'($urandom_range(255));
      case (b)
        CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OUT, CH_IN, CH_OPEN, CH_CLOSE: again = 1'b1;
        default: again = 1'b0;
      endcase
    end
    return b;
  endfunction

  function automatic logic [7:0] skipped_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CH_OPEN || b == CH_CLOSE) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic void queue_clear_and_count(input int unsigned count);
    code_backlog.push_back(CH_OPEN);
    code_backlog.push_back(CH_DEC);
    code_backlog.push_back(CH_CLOSE);
    repeat (count) code_backlog.push_back(CH_INC);
  endfunction

  function automatic logic [7:0] cell_op();
    case ($urandom_range(3))
      0:       return CH_INC;
      1:       return CH_DEC;
      2:       return CH_OUT;
      default: return CH_IN;
    endcase
  endfunction

  // every segment is bracket-balanced, keeps the pointer in range and ends
  // with the data pointer at plan_dp
  function automatic void plan_segment();
    segment_kind_e kind;
    kind = segment_kind_e'($urandom_range(5));
    case (kind)
      SEG_STRAIGHT: begin
        repeat ($urandom_range(8, 3)) begin
          case ($urandom_range(3))
            0: code_backlog.push_back(cell_op());
            1: code_backlog.push_back(cell_op());
            2: code_backlog.push_back(stray_byte());
            default: begin
              code_backlog.push_back(CH_RIGHT);
              code_backlog.push_back(cell_op());
              code_backlog.push_back(CH_LEFT);
            end
          endcase
        end
      end
      SEG_CLEAR: queue_clear_and_count($urandom_range(1));
      SEG_COUNTED: begin
        queue_clear_and_count($urandom_range(4, 1));
        code_backlog.push_back(CH_OPEN);
        code_backlog.push_back(CH_DEC);
        code_backlog.push_back(CH_RIGHT);
        repeat ($urandom_range(3, 1)) code_backlog.push_back(cell_op());
        code_backlog.push_back(CH_LEFT);
        code_backlog.push_back(CH_CLOSE);
      end
      SEG_NESTED: begin
        queue_clear_and_count($urandom_range(3, 1));
        code_backlog.push_back(CH_OPEN);
        code_backlog.push_back(CH_DEC);
        code_backlog.push_back(CH_RIGHT);
        queue_clear_and_count($urandom_range(3, 1));
        code_backlog.push_back(CH_OPEN);
        code_backlog.push_back(CH_DEC);
        code_backlog.push_back(CH_RIGHT);
        code_backlog.push_back(CH_INC);
        code_backlog.push_back(CH_LEFT);
        code_backlog.push_back(CH_CLOSE);
        code_backlog.push_back(CH_LEFT);
        code_backlog.push_back(CH_CLOSE);
      end
      SEG_SKIPPED: begin
        queue_clear_and_count(0);
        code_backlog.push_back(CH_OPEN);
        repeat ($urandom_range(6, 2)) code_backlog.push_back(skipped_byte());
        if ($urandom_range(1)) begin
          code_backlog.push_back(CH_OPEN);
          repeat ($urandom_range(4, 1)) code_backlog.push_back(skipped_byte());
          code_backlog.push_back(CH_CLOSE);
        end
        code_backlog.push_back(CH_CLOSE);
      end
      default: begin
        if (plan_dp == 0 || (plan_dp < 5 && $urandom_range(1))) begin
          code_backlog.push_back(CH_RIGHT);
          plan_dp++;
        end else begin
          code_backlog.push_back(CH_LEFT);
          plan_dp--;
        end
      end
    endcase
  endfunction

  task automatic send_request(input logic cmd, input logic [7:0] code,
                              input logic [7:0] ib, input logic eof);
    while (!steady && $urandom_range(99) < 12) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.command    <= cmd;
    req_if.code_byte  <= code;
    req_if.input_byte <= ib;
    req_if.input_eof  <= eof;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    outcome_q.push_back(run_machine_item(cmd, code, ib, eof));
  endtask

  task automatic load_code(input logic [7:0] code);
    send_request(CMD_LOAD, code, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic run_step();
    send_request(CMD_STEP, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 $urandom_range(3) == 0);
  endtask

  task automatic test_basic_ops();
    logic [7:0] prog [11];
    prog = '{CH_DEC, CH_OUT, CH_INC, CH_IN, CH_OUT, CH_IN, CH_OUT, CH_RIGHT, CH_LEFT,
             8'h00, 8'hFF};
    foreach (prog[i]) load_code(prog[i]);
    run_step();
    run_step();
    run_step();
    send_request(CMD_STEP, 8'hFF, 8'h5A, 1'b1);
    run_step();
    send_request(CMD_STEP, 8'h00, 8'hFF, 1'b0);
    repeat (5) run_step();
  endtask

  // "[-" is not a clear until its "]" is in the store
  task automatic test_clear_near_end();
    load_code(CH_OPEN);
    load_code(CH_DEC);
    run_step();
    run_step();
    load_code(CH_CLOSE);
    run_step();
    run_step();
    runnable_len = code_len;
  endtask

  task automatic test_random_programs();
    int sent;
    for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
      steady = (sent >= 150 && sent < 270);
      if (instr_ptr < runnable_len &&
          (code_backlog.size() == 0 || $urandom_range(99) < 65)) begin
        run_step();
      end else begin
        if (code_backlog.size() == 0) plan_segment();
        load_code(code_backlog.pop_front());
        if (code_backlog.size() == 0) runnable_len = code_len;
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_stop_conditions();
    ending_e ending;
    while (code_backlog.size() != 0) load_code(code_backlog.pop_front());
    while (instr_ptr < code_len) run_step();
    ending = ending_e'($urandom_range(3));
    case (ending)
      END_HALT: run_step();
      END_UNDERFLOW: begin
        repeat (data_ptr + 1) load_code(CH_LEFT);
        repeat (data_ptr + 1) run_step();
      end
      END_OPEN_UNMATCHED: begin
        queue_clear_and_count(0);
        code_backlog.push_back(CH_OPEN);
        code_backlog.push_back(CH_INC);
        code_backlog.push_back(CH_INC);
        while (code_backlog.size() != 0) load_code(code_backlog.pop_front());
        run_step();
        run_step();
      end
      default: begin
        load_code(CH_CLOSE);
        run_step();
      end
    endcase
    repeat (3) run_step();
    repeat (3) load_code(8'($urandom_range(255)));
    repeat (2) run_step();
  endtask

  initial begin
    foreach (tape_mem[i]) tape_mem[i] = '0;
    foreach (prog_mem[i]) prog_mem[i] = '0;
    code_len     = 0;
    instr_ptr    = 0;
    data_ptr     = 0;
    halt_code    = ST_OK;
    runnable_len = 0;
    plan_dp      = 0;
    steady       = 1'b0;
    fail_count   = 0;
    result_count = 0;

    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.command    <= CMD_LOAD;
    req_if.code_byte  <= 8'h00;
    req_if.input_byte <= 8'h00;
    req_if.input_eof  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_clear_near_end();
    test_random_programs();
    test_stop_conditions();

    req_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    machine_result_t got;
    machine_result_t want;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got.status       = rsp_if.status;
        got.output_valid = rsp_if.output_valid;
        got.output_byte  = rsp_if.output_byte;
        got.input_taken  = rsp_if.input_taken;
        result_count++;
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d arrived with no request outstanding", result_count);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("result %0d: expected st %0d ov %0b ob %02h it %0b, got st %0d ov %0b ob %02h it %0b",
                       result_count, want.status, want.output_valid, want.output_byte,
                       want.input_taken, got.status, got.output_valid, got.output_byte,
                       got.input_taken);
          end
        end
      end
      rsp_if.ready <= steady || ($urandom_range(99) >= 12);
    end
  end

  // no traffic on either side for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
